FILE: sv/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types, codes and helpers for the subscriber table engine.
// ----------------------------------------------------------------------------
package ste_pkg;

  // Default sizing
  localparam int MaxClients = 8;
  localparam int MaxTopics  = 4;
  localparam int TopicBytes = 8;
  localparam int MaxResults = 32;

  // Configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;
  localparam logic [31:0] TimeoutRst  = 32'd60000;
  localparam logic [31:0] IntervalRst = 32'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT  = 1'b0,
    CFG_INTERVAL = 1'b1
  } ste_cfg_e;

  // Input transaction modes
  typedef enum logic [1:0] {
    OP_SUB  = 2'd0,
    OP_ACT  = 2'd1,
    OP_PUB  = 2'd2,
    OP_TICK = 2'd3
  } ste_op_e;

  // Result status codes
  typedef enum logic [3:0] {
    ST_ACK      = 4'd0,
    ST_REJECT   = 4'd1,
    ST_TFULL    = 4'd2,
    ST_CFULL    = 4'd3,
    ST_SEEN     = 4'd4,
    ST_UNKNOWN  = 4'd5,
    ST_FORWARD  = 4'd6,
    ST_NOSUB    = 4'd7,
    ST_SKIPPED  = 4'd8,
    ST_SWEPT    = 4'd9
  } ste_status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] client_id;
    logic [63:0] topic_key;
    logic        accept_topic;
    logic [31:0] pub_value;
    logic [31:0] now_ms;
  } ste_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] dest_client;
    logic [2:0]  topic_number;
    logic [31:0] fwd_value;
    logic [3:0]  dropped_count;
    logic        last;
  } ste_out_t;

  // Classified command between front and back
  typedef struct packed {
    ste_op_e     op;
    logic [15:0] client_id;
    logic [63:0] key;
    logic        accept;
    logic [31:0] value;
    logic [31:0] now;
  } ste_cmd_t;

  // Strictly-greater wrapped time difference
  function automatic logic expired(logic [31:0] now, logic [31:0] then_t,
                                   logic [31:0] limit);
    logic [31:0] diff;
    diff = now - then_t;
    return diff > limit;
  endfunction

  function automatic ste_out_t mk_res(ste_status_e st, logic [15:0] dest,
                                      logic [2:0] tnum, logic [31:0] val,
                                      logic [3:0] drop, logic lst);
    ste_out_t r;
    r.status        = st;
    r.dest_client   = dest;
    r.topic_number  = tnum;
    r.fwd_value     = val;
    r.dropped_count = drop;
    r.last          = lst;
    return r;
  endfunction

endpackage

FILE: sv/ste_fifo.sv
// ----------------------------------------------------------------------------
// ste_fifo
// Small synchronous FIFO for any packed payload type.
// ----------------------------------------------------------------------------
module ste_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [NW-1:0]   num_q;
  logic            do_push, do_pop;

  assign full_o  = (num_q == NW'(DEPTH));
  assign empty_o = (num_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      num_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      num_q <= num_q + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

FILE: sv/ste_front.sv
// ----------------------------------------------------------------------------
// ste_front
// Accepts input transactions, classifies the mode, packs the topic key and
// queues the command for the table engine.
// ----------------------------------------------------------------------------
module ste_front import ste_pkg::*; #(
  parameter int TOPIC_BYTES = TopicBytes
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ste_in_t  in_i,
  output logic     full_o,
  input  logic     cmd_pop_i,
  output ste_cmd_t cmd_o,
  output logic     cmd_valid_o
);

  localparam logic [63:0] KeyMask = {64{1'b1}} >> (64 - 8 * TOPIC_BYTES);

  ste_cmd_t cmd;
  logic     empty;

  // Classify
  always_comb begin
    cmd.op        = ste_op_e'(in_i.mode);
    cmd.client_id = in_i.client_id;
    cmd.key       = in_i.topic_key & KeyMask;
    cmd.accept    = in_i.accept_topic;
    cmd.value     = in_i.pub_value;
    cmd.now       = in_i.now_ms;
  end

  ste_fifo #(.T(ste_cmd_t), .DEPTH(2)) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (empty)
  );

  assign cmd_valid_o = !empty;

endmodule

FILE: sv/ste_back.sv
// ----------------------------------------------------------------------------
// ste_back
// Table engine: slot scans, topic scans, publish fan-out and sweeps over the
// client table, one command at a time.
// ----------------------------------------------------------------------------
module ste_back import ste_pkg::*; #(
  parameter int MAX_CLIENTS = MaxClients,
  parameter int MAX_TOPICS  = MaxTopics
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] timeout_i,
  input  logic [31:0] interval_i,
  input  logic        cmd_valid_i,
  input  ste_cmd_t    cmd_i,
  output logic        cmd_pop_o,
  input  logic        res_full_i,
  output logic        res_push_o,
  output ste_out_t    res_o
);

  localparam int CI  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CW  = $clog2(MAX_CLIENTS + 1);
  localparam int TW  = $clog2(MAX_TOPICS + 1);
  localparam int KD  = MAX_CLIENTS * MAX_TOPICS;
  localparam int KAW = (KD > 1) ? $clog2(KD) : 1;
  localparam int RW  = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_RESOLVE, S_TOP_RD, S_TOP_CHK,
    S_PUB_RD, S_PUB_CHK, S_PUB_END, S_SWP_RD, S_SWP_CHK, S_EMIT
  } state_e;

  state_e          state_q;
  ste_cmd_t        cmd_q;
  logic [CW-1:0]   c_q;
  logic [TW-1:0]   t_q;
  logic            found_q, free_v_q;
  logic [CI-1:0]   free_q;
  logic [RW-1:0]   nres_q;
  logic            pend_v_q;
  ste_out_t        pend_q, res_q;
  logic [3:0]      drop_q;
  logic [31:0]     sweep_q;
  logic            used_q [MAX_CLIENTS];
  logic [TW-1:0]   cnt_q  [MAX_CLIENTS];

  // Slot and topic storage, registered read
  logic [15:0]     client_mem [MAX_CLIENTS];
  logic [31:0]     seen_mem   [MAX_CLIENTS];
  logic [63:0]     key_mem    [KD];
  logic [15:0]     client_rd_q;
  logic [31:0]     seen_rd_q;
  logic [63:0]     key_rd_q;

  logic [CI-1:0]   ci;
  logic            used_c, t_end, key_hit, fwd_take, last_slot, new_slot;
  logic [TW-1:0]   cnt_c;
  logic [KAW-1:0]  rd_k, key_wa;
  logic            seen_we, key_we;
  logic [CI-1:0]   seen_wa;
  logic [2:0]      tnum_hit, tnum_new;
  logic            swp_hit;
  logic [3:0]      drop_n;
  ste_out_t        fwd;

  assign ci        = c_q[CI-1:0];
  assign used_c    = used_q[ci];
  assign cnt_c     = cnt_q[ci];
  assign t_end     = (t_q >= cnt_c);
  assign key_hit   = (key_rd_q == cmd_q.key);
  assign last_slot = (c_q == CW'(MAX_CLIENTS - 1));
  assign rd_k      = KAW'(int'(ci) * MAX_TOPICS + int'(t_q));
  assign key_wa    = KAW'(int'(ci) * MAX_TOPICS + int'(cnt_c));
  assign tnum_hit  = 3'(int'(t_q) + 1);
  assign tnum_new  = 3'(int'(cnt_c) + 1);

  // Forward candidate while scanning for a publish
  assign fwd_take = (state_q == S_PUB_CHK) && used_c && !t_end && key_hit &&
                    (nres_q < RW'(MaxResults));
  assign fwd      = mk_res(ST_FORWARD, client_rd_q, tnum_hit, cmd_q.value, 4'd0, 1'b0);

  // Sweep drop accounting, saturating
  assign swp_hit = used_c && expired(cmd_q.now, seen_rd_q, timeout_i);
  assign drop_n  = (swp_hit && drop_q != 4'hF) ? drop_q + 4'd1 : drop_q;

  // Table write strobes
  assign new_slot = (state_q == S_RESOLVE) && (cmd_q.op == OP_SUB) && !found_q && free_v_q;
  assign seen_we  = ((state_q == S_RESOLVE) && found_q) || new_slot;
  assign seen_wa  = found_q ? ci : free_q;
  assign key_we   = (state_q == S_TOP_CHK) && t_end && (cnt_c < TW'(MAX_TOPICS)) &&
                    cmd_q.accept;

  // Result queue handshake
  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign res_push_o = !res_full_i &&
                      ((state_q == S_EMIT) || (fwd_take && pend_v_q));
  assign res_o      = (state_q == S_EMIT) ? res_q : pend_q;

  // Memories
  always_ff @(posedge clk_i) begin
    if (new_slot) begin
      client_mem[free_q] <= cmd_q.client_id;
    end
    client_rd_q <= client_mem[ci];
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= cmd_q.now;
    end
    seen_rd_q <= seen_mem[ci];
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= cmd_q.key;
    end
    key_rd_q <= key_mem[rd_k];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      c_q      <= '0;
      t_q      <= '0;
      found_q  <= 1'b0;
      free_v_q <= 1'b0;
      free_q   <= '0;
      nres_q   <= '0;
      pend_v_q <= 1'b0;
      drop_q   <= '0;
      sweep_q  <= '0;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        used_q[i] <= 1'b0;
        cnt_q[i]  <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            c_q      <= '0;
            t_q      <= '0;
            free_v_q <= 1'b0;
            found_q  <= 1'b0;
            nres_q   <= '0;
            pend_v_q <= 1'b0;
            drop_q   <= '0;
            if (cmd_i.op == OP_TICK) begin
              if (expired(cmd_i.now, sweep_q, interval_i)) begin
                sweep_q <= cmd_i.now;
                state_q <= S_SWP_RD;
              end else begin
                res_q   <= mk_res(ST_SKIPPED, 16'd0, 3'd0, 32'd0, 4'd0, 1'b1);
                state_q <= S_EMIT;
              end
            end else if (cmd_i.op == OP_PUB) begin
              state_q <= S_PUB_RD;
            end else begin
              state_q <= S_FIND_RD;
            end
          end
        end

        S_FIND_RD: state_q <= S_FIND_CHK;

        // Look up the client, remember the first free slot
        S_FIND_CHK: begin
          if (!used_c && !free_v_q) begin
            free_v_q <= 1'b1;
            free_q   <= ci;
          end
          if (used_c && client_rd_q == cmd_q.client_id) begin
            found_q <= 1'b1;
            state_q <= S_RESOLVE;
          end else if (last_slot) begin
            state_q <= S_RESOLVE;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_FIND_RD;
          end
        end

        S_RESOLVE: begin
          if (cmd_q.op == OP_ACT) begin
            res_q   <= mk_res(found_q ? ST_SEEN : ST_UNKNOWN, cmd_q.client_id,
                              3'd0, 32'd0, 4'd0, 1'b1);
            state_q <= S_EMIT;
          end else if (found_q) begin
            state_q <= S_TOP_RD;
          end else if (free_v_q) begin
            used_q[free_q] <= 1'b1;
            cnt_q[free_q]  <= '0;
            c_q            <= CW'(free_q);
            state_q        <= S_TOP_RD;
          end else begin
            res_q   <= mk_res(ST_CFULL, cmd_q.client_id, 3'd0, 32'd0, 4'd0, 1'b1);
            state_q <= S_EMIT;
          end
        end

        S_TOP_RD: state_q <= S_TOP_CHK;

        // Match the key against the client's topics, else append it if accepted and there is room
        S_TOP_CHK: begin
          if (t_end) begin
            if (cnt_c >= TW'(MAX_TOPICS)) begin
              res_q <= mk_res(ST_TFULL, cmd_q.client_id, 3'd0, 32'd0, 4'd0, 1'b1);
            end else if (!cmd_q.accept) begin
              res_q <= mk_res(ST_REJECT, cmd_q.client_id, 3'd0, 32'd0, 4'd0, 1'b1);
            end else begin
              cnt_q[ci] <= cnt_c + 1'b1;
              res_q     <= mk_res(ST_ACK, cmd_q.client_id, tnum_new, 32'd0, 4'd0, 1'b1);
            end
            state_q <= S_EMIT;
          end else if (key_hit) begin
            res_q   <= mk_res(ST_ACK, cmd_q.client_id, tnum_hit, 32'd0, 4'd0, 1'b1);
            state_q <= S_EMIT;
          end else begin
            t_q     <= t_q + 1'b1;
            state_q <= S_TOP_RD;
          end
        end

        S_PUB_RD: state_q <= S_PUB_CHK;

        // Publish fan-out; one forward is held back to mark the final one
        S_PUB_CHK: begin
          if (!used_c || t_end) begin
            t_q <= '0;
            if (last_slot) begin
              state_q <= S_PUB_END;
            end else begin
              c_q     <= c_q + 1'b1;
              state_q <= S_PUB_RD;
            end
          end else if (fwd_take) begin
            if (!(pend_v_q && res_full_i)) begin
              pend_q   <= fwd;
              pend_v_q <= 1'b1;
              nres_q   <= nres_q + 1'b1;
              t_q      <= t_q + 1'b1;
              state_q  <= S_PUB_RD;
            end
          end else begin
            t_q     <= t_q + 1'b1;
            state_q <= S_PUB_RD;
          end
        end

        S_PUB_END: begin
          if (pend_v_q) begin
            res_q <= mk_res(ste_status_e'(pend_q.status), pend_q.dest_client,
                            pend_q.topic_number, pend_q.fwd_value,
                            pend_q.dropped_count, 1'b1);
          end else begin
            res_q <= mk_res(ST_NOSUB, cmd_q.client_id, 3'd0, 32'd0, 4'd0, 1'b1);
          end
          pend_v_q <= 1'b0;
          state_q  <= S_EMIT;
        end

        S_SWP_RD: state_q <= S_SWP_CHK;

        // Drop timed-out clients
        S_SWP_CHK: begin
          if (swp_hit) begin
            used_q[ci] <= 1'b0;
            cnt_q[ci]  <= '0;
          end
          drop_q <= drop_n;
          if (last_slot) begin
            res_q   <= mk_res(ST_SWEPT, 16'd0, 3'd0, 32'd0, drop_n, 1'b1);
            state_q <= S_EMIT;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_SWP_RD;
          end
        end

        S_EMIT: begin
          if (!res_full_i) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/subscriber_table_engine.sv
// A subscriber table engine with queue-style ports on both sides. Each
// transaction is handled alone by a sequencer that walks the client table,
// taking each client slot as a registered table read, then a compare, and
// each stored topic key the same way. A publish can also wait on a full
// result queue. A two-entry command queue in front and a four-entry result
// queue behind let the ports run while the engine is busy. Configuration
// writes take effect at once and are meant for when the block is idle.
// ----------------------------------------------------------------------------
// subscriber_table_engine
// Client table with topic subscriptions, publish fan-out and idle sweeps.
// ----------------------------------------------------------------------------
module subscriber_table_engine import ste_pkg::*; #(
  parameter int MAX_CLIENTS = MaxClients,
  parameter int MAX_TOPICS  = MaxTopics,
  parameter int TOPIC_BYTES = TopicBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  ste_in_t             in_data_i,
  output logic                full,
  input  logic                pop,
  output ste_out_t            out_data_o,
  output logic                empty,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [31:0] timeout_q, interval_q;
  ste_cmd_t    cmd;
  logic        cmd_valid, cmd_pop;
  logic        res_push, res_full;
  ste_out_t    res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= TimeoutRst;
      interval_q <= IntervalRst;
    end else if (cfg_we_i) begin
      case (ste_cfg_e'(cfg_idx_i))
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
        CFG_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ste_front #(.TOPIC_BYTES(TOPIC_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_i        (in_data_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  ste_back #(.MAX_CLIENTS(MAX_CLIENTS), .MAX_TOPICS(MAX_TOPICS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .interval_i  (interval_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Result queue
  ste_fifo #(.T(ste_out_t), .DEPTH(4)) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_data_o),
    .empty_o (empty)
  );

  // Checks
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed into a full queue");

  a_cmd_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("command popped from an empty queue");

  a_one_txn_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !cmd_pop) else $error("engine took two commands back to back");

endmodule
